### sv/hrf_pkg.sv
package hrf_pkg;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_HNAME  = 4'd1,
        PH_CLVAL  = 4'd2,
        PH_TEVAL  = 4'd3,
        PH_BODY   = 4'd4,
        PH_CSIZE  = 4'd5,
        PH_CDATA  = 4'd6,
        PH_CDCR   = 4'd7,
        PH_CDLF   = 4'd8,
        PH_LASTCR = 4'd9,
        PH_LASTLF = 4'd10
    } phase_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_DUP_LEN   = 4'd1,
        ERR_BAD_LEN   = 4'd2,
        ERR_DUP_ENC   = 4'd3,
        ERR_EMPTY_ENC = 4'd4,
        ERR_BAD_ENC   = 4'd5,
        ERR_BAD_END   = 4'd6,
        ERR_BAD_DATA  = 4'd7,
        ERR_OVERFLOW  = 4'd8
    } err_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       msg_done;
        err_t       error_code;
    } res_t;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    localparam logic [4:0] CL_NAME_LEN = 5'd15;
    localparam logic [4:0] TE_NAME_LEN = 5'd18;
    localparam logic [2:0] TE_VAL_LEN  = 3'd7;

    // "Content-Length:"
    function automatic logic [7:0] cl_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = "C";
            5'd1:    c = "o";
            5'd2:    c = "n";
            5'd3:    c = "t";
            5'd4:    c = "e";
            5'd5:    c = "n";
            5'd6:    c = "t";
            5'd7:    c = "-";
            5'd8:    c = "L";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "g";
            5'd12:   c = "t";
            5'd13:   c = "h";
            5'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Transfer-Encoding:"
    function automatic logic [7:0] te_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = "T";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "E";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            5'd17:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Chunked"
    function automatic logic [7:0] chunked_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "C";
            3'd1:    c = "h";
            3'd2:    c = "u";
            3'd3:    c = "n";
            3'd4:    c = "k";
            3'd5:    c = "e";
            3'd6:    c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bit 4 set when the byte is a hex digit, value in the low nibble
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [7:0] t;
        logic [4:0] r;
        r = 5'd0;
        if (ch >= "0" && ch <= "9") begin
            t = ch - "0";
            r = {1'b1, t[3:0]};
        end else if (ch >= "a" && ch <= "f") begin
            t = ch - "a" + 8'd10;
            r = {1'b1, t[3:0]};
        end else if (ch >= "A" && ch <= "F") begin
            t = ch - "A" + 8'd10;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

endpackage

### sv/hrf_in_reg.sv
module hrf_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // take a word whenever the register is empty or the held one leaves this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;

endmodule

### sv/hrf_parser.sv
module hrf_parser #(
    parameter int COUNT_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  logic [7:0]    in_data,
    output hrf_pkg::res_t res
);

    localparam int WIDE = COUNT_BITS + 4;

    hrf_pkg::phase_t         phase_reg, phase_next;
    logic                    crlf_reg, crlf_next;
    logic                    empty_reg, empty_next;
    logic [4:0]              npos_reg, npos_next;
    logic [1:0]              flags_reg, flags_next;
    logic [2:0]              vpos_reg, vpos_next;
    logic                    len_seen_reg, len_seen_next;
    logic                    chk_seen_reg, chk_seen_next;
    logic [COUNT_BITS-1:0]   blen_reg, blen_next;
    logic [COUNT_BITS-1:0]   rem_reg, rem_next;

    hrf_pkg::err_t           step_err;
    logic                    step_done;
    logic                    restart;
    logic [1:0]              cur_flags;
    logic                    f0, f1;
    logic [4:0]              pos_inc;

    logic                    is_ws;
    logic                    is_digit;
    logic [7:0]              digit_full;
    logic [WIDE-1:0]         dec_sum;
    logic                    dec_ovf;
    logic [4:0]              hex;
    logic                    hex_ovf;
    logic                    rem_nz;
    logic [COUNT_BITS-1:0]   rem_dec;
    logic                    rem_le1;

    assign is_ws      = (in_data == hrf_pkg::CH_SP) || (in_data == hrf_pkg::CH_TAB);
    assign is_digit   = (in_data >= hrf_pkg::CH_0) && (in_data <= hrf_pkg::CH_9);
    assign digit_full = in_data - hrf_pkg::CH_0;

    // acc*10 + d; overflow when anything lands above the count width
    assign dec_sum = {1'b0, blen_reg, 3'b000} + {3'b000, blen_reg, 1'b0}
                   + {{COUNT_BITS{1'b0}}, digit_full[3:0]};
    assign dec_ovf = (dec_sum[WIDE-1:COUNT_BITS] != 4'd0);

    assign hex     = hrf_pkg::hex_digit(in_data);
    assign hex_ovf = (rem_reg[COUNT_BITS-1 -: 4] != 4'd0);

    assign rem_nz  = (rem_reg != '0);
    assign rem_dec = rem_reg - {{(COUNT_BITS-1){1'b0}}, rem_nz};
    assign rem_le1 = (rem_reg[COUNT_BITS-1:1] == '0);

    always_comb begin
        phase_next    = phase_reg;
        crlf_next     = crlf_reg;
        empty_next    = empty_reg;
        npos_next     = npos_reg;
        flags_next    = flags_reg;
        vpos_next     = vpos_reg;
        len_seen_next = len_seen_reg;
        chk_seen_next = chk_seen_reg;
        blen_next     = blen_reg;
        rem_next      = rem_reg;
        step_err      = hrf_pkg::ERR_NONE;
        step_done     = 1'b0;
        restart       = 1'b0;
        cur_flags     = flags_reg;
        f0            = 1'b0;
        f1            = 1'b0;
        pos_inc       = npos_reg + 5'd1;

        case (phase_reg)
            hrf_pkg::PH_BODY, hrf_pkg::PH_CDATA: begin
                rem_next = rem_dec;
                if (rem_le1) begin
                    if (phase_reg == hrf_pkg::PH_BODY) begin
                        step_done = 1'b1;
                    end else begin
                        phase_next = hrf_pkg::PH_CDCR;
                    end
                end
            end
            hrf_pkg::PH_CDCR: begin
                if (in_data == hrf_pkg::CH_CR) begin
                    phase_next = hrf_pkg::PH_CDLF;
                end else begin
                    step_err = hrf_pkg::ERR_BAD_DATA;
                end
            end
            hrf_pkg::PH_CDLF: begin
                if (in_data == hrf_pkg::CH_LF) begin
                    phase_next = hrf_pkg::PH_CSIZE;
                    rem_next   = '0;
                    flags_next = 2'b00;
                end else begin
                    step_err = hrf_pkg::ERR_BAD_DATA;
                end
            end
            hrf_pkg::PH_LASTCR: begin
                if (in_data == hrf_pkg::CH_CR) begin
                    phase_next = hrf_pkg::PH_LASTLF;
                end else begin
                    step_err = hrf_pkg::ERR_BAD_END;
                end
            end
            hrf_pkg::PH_LASTLF: begin
                if (in_data == hrf_pkg::CH_LF) begin
                    step_done = 1'b1;
                end else begin
                    step_err = hrf_pkg::ERR_BAD_END;
                end
            end
            hrf_pkg::PH_START, hrf_pkg::PH_HNAME, hrf_pkg::PH_CLVAL,
            hrf_pkg::PH_TEVAL, hrf_pkg::PH_CSIZE: begin
                if (crlf_reg && in_data == hrf_pkg::CH_LF) begin
                    // end of line
                    crlf_next = 1'b0;
                    case (phase_reg)
                        hrf_pkg::PH_HNAME: begin
                            if (empty_reg) begin
                                if (chk_seen_reg) begin
                                    phase_next = hrf_pkg::PH_CSIZE;
                                    rem_next   = '0;
                                    flags_next = 2'b00;
                                end else if (len_seen_reg && blen_reg != '0) begin
                                    phase_next = hrf_pkg::PH_BODY;
                                    rem_next   = blen_reg;
                                end else begin
                                    step_done = 1'b1;
                                end
                            end else begin
                                phase_next = hrf_pkg::PH_HNAME;
                                empty_next = 1'b1;
                                npos_next  = 5'd0;
                                flags_next = 2'b11;
                            end
                        end
                        hrf_pkg::PH_CLVAL: begin
                            if (vpos_reg == 3'd0) begin
                                step_err = hrf_pkg::ERR_BAD_LEN;
                            end else begin
                                phase_next = hrf_pkg::PH_HNAME;
                                empty_next = 1'b1;
                                npos_next  = 5'd0;
                                flags_next = 2'b11;
                            end
                        end
                        hrf_pkg::PH_TEVAL: begin
                            if (vpos_reg == 3'd0) begin
                                step_err = hrf_pkg::ERR_EMPTY_ENC;
                            end else if (vpos_reg != hrf_pkg::TE_VAL_LEN) begin
                                step_err = hrf_pkg::ERR_BAD_ENC;
                            end else begin
                                phase_next = hrf_pkg::PH_HNAME;
                                empty_next = 1'b1;
                                npos_next  = 5'd0;
                                flags_next = 2'b11;
                            end
                        end
                        hrf_pkg::PH_CSIZE: begin
                            phase_next = rem_nz ? hrf_pkg::PH_CDATA : hrf_pkg::PH_LASTCR;
                        end
                        default: begin
                            phase_next = hrf_pkg::PH_HNAME;
                            empty_next = 1'b1;
                            npos_next  = 5'd0;
                            flags_next = 2'b11;
                        end
                    endcase
                end else begin
                    // a held CR not followed by LF counts as a line byte first
                    if (crlf_reg) begin
                        crlf_next = 1'b0;
                        case (phase_reg)
                            hrf_pkg::PH_HNAME: begin
                                empty_next = 1'b0;
                                cur_flags  = 2'b00;
                            end
                            hrf_pkg::PH_CLVAL: step_err = hrf_pkg::ERR_BAD_LEN;
                            hrf_pkg::PH_TEVAL: step_err = hrf_pkg::ERR_BAD_ENC;
                            hrf_pkg::PH_CSIZE: begin
                                if (flags_reg == 2'b00) begin
                                    cur_flags = 2'b01;
                                end
                            end
                            default: ;
                        endcase
                        flags_next = cur_flags;
                    end
                    if (step_err == hrf_pkg::ERR_NONE) begin
                        if (in_data == hrf_pkg::CH_CR) begin
                            crlf_next = 1'b1;
                        end else begin
                            case (phase_reg)
                                hrf_pkg::PH_HNAME: begin
                                    empty_next = 1'b0;
                                    if (cur_flags != 2'b00) begin
                                        f0 = cur_flags[0] && (npos_reg < hrf_pkg::CL_NAME_LEN)
                                             && (hrf_pkg::cl_char(npos_reg) == in_data);
                                        f1 = cur_flags[1] && (npos_reg < hrf_pkg::TE_NAME_LEN)
                                             && (hrf_pkg::te_char(npos_reg) == in_data);
                                        flags_next = {f1, f0};
                                        npos_next  = pos_inc;
                                        if (f0 && pos_inc == hrf_pkg::CL_NAME_LEN) begin
                                            if (len_seen_reg) begin
                                                step_err = hrf_pkg::ERR_DUP_LEN;
                                            end else begin
                                                len_seen_next = 1'b1;
                                                blen_next     = '0;
                                                vpos_next     = 3'd0;
                                                phase_next    = hrf_pkg::PH_CLVAL;
                                            end
                                        end else if (f1 && pos_inc == hrf_pkg::TE_NAME_LEN) begin
                                            if (chk_seen_reg) begin
                                                step_err = hrf_pkg::ERR_DUP_ENC;
                                            end else begin
                                                chk_seen_next = 1'b1;
                                                vpos_next     = 3'd0;
                                                phase_next    = hrf_pkg::PH_TEVAL;
                                            end
                                        end
                                    end
                                end
                                hrf_pkg::PH_CLVAL: begin
                                    if (!(is_ws && vpos_reg == 3'd0)) begin
                                        if (is_digit) begin
                                            if (dec_ovf) begin
                                                step_err = hrf_pkg::ERR_OVERFLOW;
                                            end else begin
                                                blen_next = dec_sum[COUNT_BITS-1:0];
                                                vpos_next = 3'd1;
                                            end
                                        end else begin
                                            step_err = hrf_pkg::ERR_BAD_LEN;
                                        end
                                    end
                                end
                                hrf_pkg::PH_TEVAL: begin
                                    if (!(is_ws && vpos_reg == 3'd0)) begin
                                        if (vpos_reg < hrf_pkg::TE_VAL_LEN
                                            && hrf_pkg::chunked_char(vpos_reg) == in_data) begin
                                            vpos_next = vpos_reg + 3'd1;
                                        end else begin
                                            step_err = hrf_pkg::ERR_BAD_ENC;
                                        end
                                    end
                                end
                                hrf_pkg::PH_CSIZE: begin
                                    // digits up to the first other byte, rest of line ignored
                                    if (cur_flags == 2'b00) begin
                                        if (hex[4]) begin
                                            if (hex_ovf) begin
                                                step_err = hrf_pkg::ERR_OVERFLOW;
                                            end else begin
                                                rem_next = {rem_reg[COUNT_BITS-5:0], hex[3:0]};
                                            end
                                        end else begin
                                            flags_next = 2'b01;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            default: restart = 1'b1;
        endcase

        // any error or completion starts a fresh message
        if (restart || step_err != hrf_pkg::ERR_NONE || step_done) begin
            phase_next    = hrf_pkg::PH_START;
            crlf_next     = 1'b0;
            empty_next    = 1'b1;
            npos_next     = 5'd0;
            flags_next    = 2'b11;
            vpos_next     = 3'd0;
            len_seen_next = 1'b0;
            chk_seen_next = 1'b0;
            blen_next     = '0;
            rem_next      = '0;
        end
    end

    always_comb begin
        res.body_valid = (phase_reg == hrf_pkg::PH_BODY) || (phase_reg == hrf_pkg::PH_CDATA);
        res.body_byte  = res.body_valid ? in_data : 8'h00;
        res.msg_done   = step_done;
        res.error_code = step_err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= hrf_pkg::PH_START;
            crlf_reg     <= 1'b0;
            empty_reg    <= 1'b1;
            npos_reg     <= 5'd0;
            flags_reg    <= 2'b11;
            vpos_reg     <= 3'd0;
            len_seen_reg <= 1'b0;
            chk_seen_reg <= 1'b0;
            blen_reg     <= '0;
            rem_reg      <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            crlf_reg     <= crlf_next;
            empty_reg    <= empty_next;
            npos_reg     <= npos_next;
            flags_reg    <= flags_next;
            vpos_reg     <= vpos_next;
            len_seen_reg <= len_seen_next;
            chk_seen_reg <= chk_seen_next;
            blen_reg     <= blen_next;
            rem_reg      <= rem_next;
        end
    end

    a_body_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == hrf_pkg::PH_BODY || phase_reg == hrf_pkg::PH_CDATA) |-> rem_reg != '0)
        else $error("body phase with zero remaining count");

    a_restart_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (step_done || step_err != hrf_pkg::ERR_NONE)
        |=> phase_reg == hrf_pkg::PH_START && !len_seen_reg && !chk_seen_reg && !crlf_reg)
        else $error("message end did not return to start line");

    a_done_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.msg_done |-> res.error_code == hrf_pkg::ERR_NONE && !crlf_next)
        else $error("completion flagged together with an error");

    a_cr_only_in_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        crlf_reg |-> (phase_reg == hrf_pkg::PH_START || phase_reg == hrf_pkg::PH_HNAME
                      || phase_reg == hrf_pkg::PH_CLVAL || phase_reg == hrf_pkg::PH_TEVAL
                      || phase_reg == hrf_pkg::PH_CSIZE))
        else $error("pending CR outside a line phase");

    a_value_needs_name: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == hrf_pkg::PH_CLVAL |-> len_seen_reg)
        and (phase_reg == hrf_pkg::PH_TEVAL |-> chk_seen_reg))
        else $error("header value phase without its name");

endmodule

### sv/hrf_out_reg.sv
module hrf_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  hrf_pkg::res_t res_in,
    output logic          free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,   // [7:0] body_byte, [11:8] error_code, [15:12] zero
    output logic          m_tuser,   // [0] body_valid
    output logic          m_tlast    // msg_done
);

    logic          valid_reg;
    logic          valid_next;
    hrf_pkg::res_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold the word until the receiver takes it
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, res_reg.error_code, res_reg.body_byte};
    assign m_tuser  = res_reg.body_valid;
    assign m_tlast  = res_reg.msg_done;

endmodule

### sv/http_request_framer_unit.sv
// HTTP/1.1 request framer.
// The slave channel takes the raw request stream, one byte per word in
// s_tdata[7:0]. For every byte taken the master channel gives one word:
// m_tdata[7:0] is the body byte (zero when m_tuser is low), m_tuser marks a
// payload byte, m_tlast marks the byte that completes a message and
// m_tdata[11:8] carries an error code on the byte that detects an error.
// After either, the next byte begins a new request.
// A byte is held in the input register, is parsed on its way into the
// output register, and then appears on the master side. One byte is taken
// every cycle while the master side does not stall; the single parse pass
// between the two registers sets that figure, with the header and chunk size
// counts kept in COUNT_BITS-wide registers updated in the same cycle.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// parser to the start line. When m_tready is low the output word holds, the
// input register keeps one further byte, and s_tready then drops until the
// output word is taken.
module http_request_framer_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] body_byte, [11:8] error_code, [15:12] zero
    output logic        m_tuser,   // [0] body_valid
    output logic        m_tlast    // msg_done
);

    logic          in_valid;
    logic [7:0]    in_data;
    logic          out_free;
    logic          advance;
    hrf_pkg::res_t res;

    // move a byte from the input register to the output register
    assign advance = in_valid && out_free;

    hrf_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    hrf_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_data (in_data),
        .res     (res)
    );

    hrf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res_in   (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sim/tb.sv
module tb;

    typedef struct {
        logic [7:0] data;
        bit         drain;
    } req_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    http_request_framer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    req_item_t      request_bytes [$];
    hrf_pkg::res_t  framed_words [$];
    bit        drain_next = 1'b0;
    int        mismatches = 0;
    int        bytes_sent = 0;
    int        burst_left = 20;
    int        gap_left   = 0;
    int        hold_left  = 0;
    int        holds_done = 0;
    logic [31:0] sink_cycle = 32'd0;

    // parser state mirrored from the block
    hrf_pkg::phase_t rx_phase;
    logic        cr_pending;
    logic        line_blank;
    logic [4:0]  name_pos;
    logic [1:0]  name_hits;
    logic [2:0]  val_pos;
    logic        have_len;
    logic        have_chunked;
    logic [63:0] body_len;
    logic [63:0] bytes_left;
    logic        done_flag;
    hrf_pkg::err_t fault;

    string len_hdr = "Content-Length:";
    string enc_hdr = "Transfer-Encoding:";
    string enc_val = "Chunked";
    string te_line = "Transfer-Encoding: Chunked";

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("http_request_framer_unit test failed");
        $finish;
    end

    function automatic void restart_msg();
        rx_phase     = hrf_pkg::PH_START;
        cr_pending   = 1'b0;
        line_blank   = 1'b1;
        name_pos     = 5'd0;
        name_hits    = 2'b11;
        val_pos      = 3'd0;
        have_len     = 1'b0;
        have_chunked = 1'b0;
        body_len     = 64'd0;
        bytes_left   = 64'd0;
    endfunction

    function automatic void abort_msg(input hrf_pkg::err_t code);
        fault = code;
        restart_msg();
    endfunction

    function automatic void complete_msg();
        done_flag = 1'b1;
        restart_msg();
    endfunction

    function automatic void open_header_line();
        rx_phase   = hrf_pkg::PH_HNAME;
        line_blank = 1'b1;
        name_pos   = 5'd0;
        name_hits  = 2'b11;
    endfunction

    // true when acc*base+d still fits the 32-bit counters
    function automatic bit digit_fits(input logic [63:0] acc, input logic [4:0] base,
                                      input logic [3:0] d);
        return acc <= (64'hFFFF_FFFF - d) / base;
    endfunction

    function automatic void line_byte(input logic [7:0] ch);
        logic       ws;
        logic       is_hex;
        logic [7:0] t;
        ws     = (ch == hrf_pkg::CH_SP || ch == hrf_pkg::CH_TAB);
        is_hex = 1'b1;
        if (ch >= "0" && ch <= "9") t = ch - 8'h30;
        else if (ch >= "a" && ch <= "f") t = ch - 8'h57;
        else if (ch >= "A" && ch <= "F") t = ch - 8'h37;
        else begin
            is_hex = 1'b0;
            t = 8'd0;
        end
        case (rx_phase)
            hrf_pkg::PH_HNAME: begin
                line_blank = 1'b0;
                if (name_hits == 2'b00) return;
                if (name_hits[0] && (name_pos >= hrf_pkg::CL_NAME_LEN
                                     || len_hdr[name_pos] != ch))
                    name_hits[0] = 1'b0;
                if (name_hits[1] && (name_pos >= hrf_pkg::TE_NAME_LEN
                                     || enc_hdr[name_pos] != ch))
                    name_hits[1] = 1'b0;
                name_pos++;
                if (name_hits[0] && name_pos == hrf_pkg::CL_NAME_LEN) begin
                    if (have_len) begin
                        abort_msg(hrf_pkg::ERR_DUP_LEN);
                        return;
                    end
                    have_len = 1'b1;
                    body_len = 64'd0;
                    val_pos  = 3'd0;
                    rx_phase = hrf_pkg::PH_CLVAL;
                end else if (name_hits[1] && name_pos == hrf_pkg::TE_NAME_LEN) begin
                    if (have_chunked) begin
                        abort_msg(hrf_pkg::ERR_DUP_ENC);
                        return;
                    end
                    have_chunked = 1'b1;
                    val_pos      = 3'd0;
                    rx_phase     = hrf_pkg::PH_TEVAL;
                end
            end
            hrf_pkg::PH_CLVAL: begin
                if (ws && val_pos == 3'd0) return;
                if (ch >= hrf_pkg::CH_0 && ch <= hrf_pkg::CH_9) begin
                    if (!digit_fits(body_len, 5'd10, t[3:0]))
                        abort_msg(hrf_pkg::ERR_OVERFLOW);
                    else begin
                        body_len = body_len * 10 + t[3:0];
                        val_pos  = 3'd1;
                    end
                end else begin
                    abort_msg(hrf_pkg::ERR_BAD_LEN);
                end
            end
            hrf_pkg::PH_TEVAL: begin
                if (ws && val_pos == 3'd0) return;
                if (val_pos < hrf_pkg::TE_VAL_LEN && enc_val[val_pos] == ch) val_pos++;
                else abort_msg(hrf_pkg::ERR_BAD_ENC);
            end
            hrf_pkg::PH_CSIZE: begin
                // digits stop at the first other byte; ignore the rest of the line
                if (name_hits == 2'b00) begin
                    if (!is_hex) name_hits = 2'b01;
                    else if (!digit_fits(bytes_left, 5'd16, t[3:0]))
                        abort_msg(hrf_pkg::ERR_OVERFLOW);
                    else bytes_left = bytes_left * 16 + t[3:0];
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void end_of_line();
        case (rx_phase)
            hrf_pkg::PH_HNAME: begin
                if (!line_blank) open_header_line();
                else if (have_chunked) begin
                    rx_phase   = hrf_pkg::PH_CSIZE;
                    bytes_left = 64'd0;
                    name_hits  = 2'b00;
                end else if (have_len && body_len != 0) begin
                    rx_phase   = hrf_pkg::PH_BODY;
                    bytes_left = body_len;
                end else begin
                    complete_msg();
                end
            end
            hrf_pkg::PH_CLVAL: begin
                if (val_pos == 3'd0) abort_msg(hrf_pkg::ERR_BAD_LEN);
                else open_header_line();
            end
            hrf_pkg::PH_TEVAL: begin
                if (val_pos == 3'd0) abort_msg(hrf_pkg::ERR_EMPTY_ENC);
                else if (val_pos != hrf_pkg::TE_VAL_LEN) abort_msg(hrf_pkg::ERR_BAD_ENC);
                else open_header_line();
            end
            hrf_pkg::PH_CSIZE: begin
                if (bytes_left == 0) rx_phase = hrf_pkg::PH_LASTCR;
                else rx_phase = hrf_pkg::PH_CDATA;
            end
            default: open_header_line();
        endcase
    endfunction

    function automatic hrf_pkg::res_t parse_byte(input logic [7:0] b);
        hrf_pkg::res_t r;
        r         = '0;
        done_flag = 1'b0;
        fault     = hrf_pkg::ERR_NONE;
        case (rx_phase)
            hrf_pkg::PH_BODY, hrf_pkg::PH_CDATA: begin
                r.body_valid = 1'b1;
                r.body_byte  = b;
                if (bytes_left != 0) bytes_left--;
                if (bytes_left == 0) begin
                    if (rx_phase == hrf_pkg::PH_BODY) complete_msg();
                    else rx_phase = hrf_pkg::PH_CDCR;
                end
            end
            hrf_pkg::PH_CDCR: begin
                if (b == hrf_pkg::CH_CR) rx_phase = hrf_pkg::PH_CDLF;
                else abort_msg(hrf_pkg::ERR_BAD_DATA);
            end
            hrf_pkg::PH_CDLF: begin
                if (b == hrf_pkg::CH_LF) begin
                    rx_phase   = hrf_pkg::PH_CSIZE;
                    bytes_left = 64'd0;
                    name_hits  = 2'b00;
                end else begin
                    abort_msg(hrf_pkg::ERR_BAD_DATA);
                end
            end
            hrf_pkg::PH_LASTCR: begin
                if (b == hrf_pkg::CH_CR) rx_phase = hrf_pkg::PH_LASTLF;
                else abort_msg(hrf_pkg::ERR_BAD_END);
            end
            hrf_pkg::PH_LASTLF: begin
                if (b == hrf_pkg::CH_LF) complete_msg();
                else abort_msg(hrf_pkg::ERR_BAD_END);
            end
            default: begin
                if (cr_pending && b == hrf_pkg::CH_LF) begin
                    cr_pending = 1'b0;
                    end_of_line();
                end else begin
                    // a CR not followed by LF is plain line content
                    if (cr_pending) begin
                        cr_pending = 1'b0;
                        line_byte(hrf_pkg::CH_CR);
                    end
                    if (fault == hrf_pkg::ERR_NONE) begin
                        if (b == hrf_pkg::CH_CR) cr_pending = 1'b1;
                        else line_byte(b);
                    end
                end
            end
        endcase
        r.msg_done   = done_flag;
        r.error_code = fault;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        $display("mismatch on %s at word %0d: expected %h, got %h",
                 what, bytes_sent, want, got);
        mismatches++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        request_bytes.push_back('{data: b, drain: drain_next});
        drain_next = 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_line(input string s);
        push_text(s);
        push_byte(hrf_pkg::CH_CR);
        push_byte(hrf_pkg::CH_LF);
    endtask

    task automatic push_random(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic string blanks();
        case ($urandom_range(0, 3))
            0: return "";
            1: return " ";
            2: return "\t";
            default: return "  \t";
        endcase
    endfunction

    function automatic string size_text(input longint unsigned n);
        string s;
        s = $sformatf("%0h", n);
        if ($urandom_range(0, 1)) s = s.toupper();
        if ($urandom_range(0, 3) == 0) s = {"0", s};
        case ($urandom_range(0, 3))
            0: s = {s, ";ext=1"};
            1: s = {s, " x"};
            default: ;
        endcase
        return s;
    endfunction

    // header lines that must not match either name
    function automatic string filler_line();
        case ($urandom_range(0, 8))
            0: return "Host: example";
            1: return "content-length: 7";
            2: return "Content-Lengt: 3";
            3: return " Content-Length: 4";
            4: return "Transfer-Encoding chunked";
            5: return "X-Len: Content-Length: 9";
            6: return "X-A\nB: c";
            7: return "Transfer-Encodingx: Chunked";
            default: return "Accept: */*";
        endcase
    endfunction

    task automatic broken_request();
        logic [7:0] b;
        case ($urandom_range(0, 10))
            0: begin
                push_line("Content-Length: 5");
                push_line($sformatf("Content-Length: %0d", $urandom_range(0, 9)));
            end
            1: push_line({"Content-Length:", blanks()});
            2: begin
                push_text({"Content-Length: ", $sformatf("%0d", $urandom_range(1, 99))});
                case ($urandom_range(0, 2))
                    0: push_line("a");
                    1: push_line(" 2");
                    default: begin
                        push_byte(hrf_pkg::CH_CR);
                        push_line("2");
                    end
                endcase
            end
            3: begin
                push_line(te_line);
                push_line({"Transfer-Encoding:", blanks(), "Chunked"});
            end
            4: push_line({"Transfer-Encoding:", blanks()});
            5: begin
                case ($urandom_range(0, 4))
                    0: push_line("Transfer-Encoding: chunked");
                    1: push_line("Transfer-Encoding: Chunked ");
                    2: push_line("Transfer-Encoding: Chunk");
                    3: push_line("Transfer-Encoding: Chunkedx");
                    default: push_line("Transfer-Encoding: gzip");
                endcase
            end
            6: begin
                push_line(te_line);
                push_line("");
                push_line("0");
                b = 8'($urandom_range(0, 255));
                if (b == hrf_pkg::CH_CR) b = "X";
                push_byte(b);
            end
            7: begin
                push_line(te_line);
                push_line("");
                push_line("3");
                push_random(3);
                if ($urandom_range(0, 1)) push_byte(hrf_pkg::CH_CR);
                b = 8'($urandom_range(0, 255));
                if (b == hrf_pkg::CH_CR || b == hrf_pkg::CH_LF) b = "Y";
                push_byte(b);
            end
            8: push_line($sformatf("Content-Length: %0d", 64'h1_0000_0000 + $urandom));
            9: begin
                push_line(te_line);
                push_line("");
                push_line($sformatf("%0h", 64'h1_0000_0000 + $urandom));
            end
            default: begin
                push_text("Transfer-Encoding: Chun");
                push_byte(hrf_pkg::CH_CR);
                push_line("ked");
            end
        endcase
        // close out whatever state the error left behind
        push_line("");
        push_line("");
    endtask

    task automatic random_request();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0) begin
            push_line("");
        end else begin
            push_text("GET /");
            repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range("a", "z")));
            push_line(" HTTP/1.1");
        end
        repeat ($urandom_range(0, 2)) push_line(filler_line());
        if (kind < 35) begin
            n = $urandom_range(0, 24);
            push_line({"Content-Length:", blanks(), $sformatf("%0d", n)});
            if ($urandom_range(0, 2) == 0) push_line(filler_line());
            push_line("");
            push_random(n);
        end else if (kind < 65) begin
            push_line({"Transfer-Encoding:", blanks(), "Chunked"});
            if ($urandom_range(0, 3) == 0)
                push_line($sformatf("Content-Length: %0d", $urandom_range(1, 9)));
            push_line("");
            repeat ($urandom_range(0, 3)) begin
                n = $urandom_range(1, 12);
                push_line(size_text(64'(n)));
                push_random(n);
                push_line("");
            end
            case ($urandom_range(0, 3))
                0: push_line("");
                1: push_line("000");
                default: push_line(size_text(64'd0));
            endcase
            push_line("");
        end else if (kind < 75) begin
            push_line("");
        end else if (kind < 90) begin
            broken_request();
        end else begin
            repeat ($urandom_range(1, 30)) begin
                case ($urandom_range(0, 5))
                    0: push_byte(hrf_pkg::CH_CR);
                    1: push_byte(hrf_pkg::CH_LF);
                    default: push_byte(8'($urandom_range(0, 255)));
                endcase
            end
            push_line("");
            push_line("");
        end
    endtask

    // driver: bursts of words with random gaps in between
    always @(posedge aclk) begin : drive
        req_item_t it;
        logic      offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                framed_words.push_back(parse_byte(s_tdata));
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (request_bytes.size() != 0 &&
                             !(request_bytes[0].drain && framed_words.size() != 0)) begin
                    it    = request_bytes.pop_front();
                    offer = 1'b1;
                    s_tdata <= it.data;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    // receiver: stall pattern steps through four modes chosen by sink_cycle[9:8], plus two long hold-offs
    always @(posedge aclk) begin : sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            sink_cycle++;
            if (hold_left == 0 && ((holds_done == 0 && bytes_sent >= 300) ||
                                   (holds_done == 1 && bytes_sent >= 1000))) begin
                hold_left = 300;
                holds_done++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (sink_cycle[9:8])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= 1'($urandom_range(0, 1));
                    2'd2: m_tready <= (sink_cycle[1:0] == 2'd0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : watch
        hrf_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (framed_words.size() == 0) begin
                note_mismatch("unexpected word", 16'd0, m_tdata);
            end else begin
                want = framed_words.pop_front();
                if (m_tdata[7:0] !== want.body_byte)
                    note_mismatch("body_byte", {8'd0, want.body_byte}, {8'd0, m_tdata[7:0]});
                if (m_tdata[11:8] !== want.error_code)
                    note_mismatch("error_code", {12'd0, want.error_code},
                                  {12'd0, m_tdata[11:8]});
                if (m_tdata[15:12] !== 4'd0)
                    note_mismatch("tdata pad", 16'd0, {12'd0, m_tdata[15:12]});
                if (m_tuser !== want.body_valid)
                    note_mismatch("body_valid", {15'd0, want.body_valid}, {15'd0, m_tuser});
                if (m_tlast !== want.msg_done)
                    note_mismatch("msg_done", {15'd0, want.msg_done}, {15'd0, m_tlast});
            end
        end
    end

    initial begin
        int pauses;
        pauses = 0;
        restart_msg();

        // empty start line, no header lines
        push_line("");
        push_line("");
        // lone CR and bare LF in the start line, zero length
        push_text("GET");
        push_byte(hrf_pkg::CH_CR);
        push_text("X");
        push_byte(hrf_pkg::CH_LF);
        push_line(" /");
        push_line("Content-Length: 0");
        push_line("");
        // length body with extreme bytes
        push_line("P");
        push_line("Content-Length:\t 3");
        push_line("");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h5A);
        // both headers: chunked wins
        push_line("P");
        push_line(te_line);
        push_line("Content-Length: 2");
        push_line("");
        push_line("3;x");
        push_byte(8'hA5);
        push_byte(hrf_pkg::CH_CR);
        push_byte(hrf_pkg::CH_LF);
        push_line("");
        push_line("0");
        push_line("");
        // size line without digits counts as the last chunk
        push_line("P");
        push_line(te_line);
        push_line("");
        push_line(";z");
        push_line("");
        // error cases, each closed by an empty message
        push_line("P");
        push_line("Content-Length: 1");
        push_line("Content-Length: 1");
        push_line("");
        push_line("");
        push_line("P");
        push_line("Content-Length:");
        push_line("");
        push_line("");
        push_line("P");
        push_line("Content-Length: 7 ");
        push_line("");
        push_line("");
        push_line("P");
        push_line(te_line);
        push_line(te_line);
        push_line("");
        push_line("");
        push_line("P");
        push_line("Transfer-Encoding: \t");
        push_line("");
        push_line("");
        push_line("P");
        push_line("Transfer-Encoding: Chunked ");
        push_line("");
        push_line("");
        push_line("P");
        push_line(te_line);
        push_line("");
        push_line("0");
        push_text("X");
        push_line("");
        push_line("");
        push_line("P");
        push_line(te_line);
        push_line("");
        push_line("1");
        push_text("qZ");
        push_line("");
        push_line("");
        push_line("P");
        push_line("Content-Length: 42949672950");
        push_line("");
        push_line("");
        push_line("P");
        push_line(te_line);
        push_line("");
        push_line("FFFFFFFF0");
        push_line("");
        push_line("");

        while (request_bytes.size() < 1550) begin
            // hold the sender until the block has drained
            if (pauses < 2 && request_bytes.size() > 500 + 500 * pauses) begin
                drain_next = 1'b1;
                pauses++;
            end
            random_request();
        end

        wait (aresetn);
        do @(posedge aclk);
        while (request_bytes.size() != 0 || s_tvalid || framed_words.size() != 0);
        repeat (10) @(posedge aclk);

        if (mismatches == 0) begin
            $display("http_request_framer_unit test passed");
        end else begin
            $display("http_request_framer_unit test failed");
        end
        $finish;
    end

endmodule
